// File: design/lrg_pkg.sv
// Shared types and constants for the letterbox resize geometry block.
`default_nettype none
package lrg_pkg;

  localparam int DIM_W   = 13;
  localparam int RAT_W   = 16;
  localparam int SCL_W   = 29;
  localparam int FRAC_W  = 16;
  localparam int ONUM_W  = 26;
  localparam int ODEN_W  = DIM_W + 1;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 16;
  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SIZE   = 2'd1;
  localparam logic [1:0] ST_POLICY = 2'd2;

  localparam logic [IDX_W-1:0] REG_TGT_W   = 3'd0;
  localparam logic [IDX_W-1:0] REG_TGT_H   = 3'd1;
  localparam logic [IDX_W-1:0] REG_STRETCH = 3'd2;
  localparam logic [IDX_W-1:0] REG_RAT_W   = 3'd3;
  localparam logic [IDX_W-1:0] REG_RAT_H   = 3'd4;

  // classified word handed from front to back
  typedef struct packed {
    logic [1:0]        status;
    logic              stretch;
    logic              wlim;
    logic [DIM_W-1:0]  tw;
    logic [DIM_W-1:0]  th;
    logic [DIM_W-1:0]  sw;
    logic [DIM_W-1:0]  sh;
    logic [ONUM_W-1:0] onum;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             stretch;
    logic             wlim;
    logic [DIM_W-1:0] tw;
    logic [DIM_W-1:0] th;
  } side_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             aspect_kept;
    logic [DIM_W-1:0] out_width;
    logic [DIM_W-1:0] out_height;
    logic [DIM_W-1:0] left_pad;
    logic [DIM_W-1:0] pad_top;
    logic [DIM_W-1:0] pad_right;
    logic [DIM_W-1:0] pad_bottom;
    logic [SCL_W-1:0] scale_x;
    logic [SCL_W-1:0] scale_y;
    logic [SCL_W-1:0] uniform_scale;
  } res_t;

endpackage
`default_nettype wire

// File: design/lrg_fifo.sv
// Small register queue used between front and back and on the result side.
`default_nettype none
module lrg_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

// File: design/lrg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module lrg_div #(
  parameter int NW = 29,
  parameter int DW = 13,
  parameter int QW = 29
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic [QW-1:0]      quo
);
  localparam int RW = DW + QW;

  logic [RW-1:0] rem_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [DW-1:0] den_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [RW-1:0] rem_in, sub;
    logic [QW-1:0] q_in, q_nxt;
    logic [DW-1:0] den_in;
    logic          ge;
    if (k == 0) begin : g_first
      assign rem_in = RW'(num);
      assign q_in   = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign den_in = den_r[k-1];
    end
    assign sub = RW'(den_in) << B;
    assign ge  = (rem_in >= sub);
    always_comb begin
      q_nxt    = q_in;
      q_nxt[B] = ge;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? rem_in - sub : rem_in;
        q_r[k]   <= q_nxt;
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = q_r[QW-1];
endmodule
`default_nettype wire

// File: design/lrg_front.sv
// Front: configuration registers, size checks, ratio match and limiting axis.
`default_nettype none
module lrg_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [lrg_pkg::IDX_W-1:0] cfg_idx,
  input  wire logic [lrg_pkg::CFG_W-1:0] cfg_data,
  input  wire logic [lrg_pkg::DIM_W-1:0] src_width,
  input  wire logic [lrg_pkg::DIM_W-1:0] src_height,
  output lrg_pkg::item_t                item
);
  import lrg_pkg::*;

  logic [DIM_W-1:0] tw_r, th_r;
  logic             str_r;
  logic [RAT_W-1:0] rw_r, rh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r  <= 13'd640;
      th_r  <= 13'd640;
      str_r <= 1'b0;
      rw_r  <= 16'd16;
      rh_r  <= 16'd9;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TGT_W:   tw_r  <= cfg_data[DIM_W-1:0];
        REG_TGT_H:   th_r  <= cfg_data[DIM_W-1:0];
        REG_STRETCH: str_r <= cfg_data[0];
        REG_RAT_W:   rw_r  <= cfg_data;
        REG_RAT_H:   rh_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    return (d != '0) && (d <= MAX_DIM);
  endfunction

  logic [2*DIM_W-1:0]       p_ws, p_hs;
  logic [DIM_W+RAT_W-1:0]   m_w, m_h;
  logic size_bad, pol_bad, wlim;

  always_comb begin
    p_ws     = tw_r * src_height;
    p_hs     = th_r * src_width;
    m_w      = src_width * rh_r;
    m_h      = src_height * rw_r;
    size_bad = !(dim_ok(src_width) && dim_ok(src_height) && dim_ok(tw_r) && dim_ok(th_r));
    pol_bad  = str_r && (rw_r == '0 || rh_r == '0);
    wlim     = (p_ws <= p_hs);
    item.status  = size_bad ? ST_SIZE : (pol_bad ? ST_POLICY : ST_OK);
    item.stretch = str_r && (m_w == m_h);
    item.wlim    = wlim;
    item.tw      = tw_r;
    item.th      = th_r;
    item.sw      = src_width;
    item.sh      = src_height;
    // twice the cross product plus the divisor gives round half up
    item.onum    = wlim ? ONUM_W'({p_ws, 1'b0}) + ONUM_W'(src_width)
                        : ONUM_W'({p_hs, 1'b0}) + ONUM_W'(src_height);
  end
endmodule
`default_nettype wire

// File: design/lrg_back.sv
// Back: dividers for scales and the free axis, then clamp and padding split.
`default_nettype none
module lrg_back (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  mid_empty,
  input  lrg_pkg::item_t mid_item,
  output logic       mid_pop,
  input  wire logic  res_full,
  output logic       res_push,
  output lrg_pkg::res_t res
);
  import lrg_pkg::*;

  logic          en;
  logic [SCL_W-1:0] v_r;
  side_t         side_r [SCL_W];
  side_t         side_in, sd;
  logic [SCL_W-1:0] qx, qy, qo;
  logic [SCL_W-1:0] nx, ny;

  assign en       = !(v_r[SCL_W-1] && res_full);
  assign mid_pop  = en && !mid_empty;
  assign res_push = v_r[SCL_W-1] && !res_full;

  assign nx = (SCL_W'(mid_item.tw) << FRAC_W) + SCL_W'(mid_item.sw >> 1);
  assign ny = (SCL_W'(mid_item.th) << FRAC_W) + SCL_W'(mid_item.sh >> 1);

  lrg_div #(.NW(SCL_W), .DW(DIM_W), .QW(SCL_W)) u_divx (
    .clk(clk), .en(en), .num(nx), .den(mid_item.sw), .quo(qx));
  lrg_div #(.NW(SCL_W), .DW(DIM_W), .QW(SCL_W)) u_divy (
    .clk(clk), .en(en), .num(ny), .den(mid_item.sh), .quo(qy));
  lrg_div #(.NW(ONUM_W), .DW(ODEN_W), .QW(SCL_W)) u_divo (
    .clk(clk), .en(en), .num(mid_item.onum),
    .den(mid_item.wlim ? {mid_item.sw, 1'b0} : {mid_item.sh, 1'b0}), .quo(qo));

  assign side_in = '{status: mid_item.status, stretch: mid_item.stretch,
                     wlim: mid_item.wlim, tw: mid_item.tw, th: mid_item.th};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[SCL_W-2:0], mid_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < SCL_W; i++) side_r[i] <= side_r[i-1];
    end
  end

  logic [DIM_W-1:0] lim, fr, rw, rh, remw, remh;
  assign sd = side_r[SCL_W-1];

  always_comb begin
    lim = sd.wlim ? sd.th : sd.tw;
    // clamp the free axis to 1..target
    if (qo == '0)                 fr = DIM_W'(1);
    else if (qo > SCL_W'(lim))    fr = lim;
    else                          fr = qo[DIM_W-1:0];
    rw   = sd.wlim ? sd.tw : fr;
    rh   = sd.wlim ? fr : sd.th;
    remw = sd.tw - rw;
    remh = sd.th - rh;
    res  = '0;
    res.status = sd.status;
    if (sd.status != ST_OK) begin
      res.status = sd.status;
    end else if (sd.stretch) begin
      res.out_width  = sd.tw;
      res.out_height = sd.th;
      res.scale_x    = qx;
      res.scale_y    = qy;
    end else begin
      res.aspect_kept   = 1'b1;
      res.out_width     = rw;
      res.out_height    = rh;
      res.left_pad      = remw >> 1;
      res.pad_top       = remh >> 1;
      res.pad_right     = remw - (remw >> 1);
      res.pad_bottom    = remh - (remh >> 1);
      res.scale_x       = sd.wlim ? qx : qy;
      res.scale_y       = sd.wlim ? qx : qy;
      res.uniform_scale = sd.wlim ? qx : qy;
    end
  end
endmodule
`default_nettype wire

// File: design/letterbox_resize_geometry.sv
// Top level: letterbox resize geometry, front classifier, queue, divider back end.
// Usage:
//   Input channel: drive in_src_width/in_src_height with in_push; a word is
//   taken at a clock edge where in_push is high and in_full is low.
//   Result channel: while out_empty is low the oldest result sits on the out_
//   ports; raise out_pop to take it.
//   Configuration: cfg_we with cfg_idx selects target width, target height,
//   stretch enable, ratio width, ratio height; write only while idle.
// Throughput: one word per cycle while the result queue is not full, set by
//   the fully pipelined dividers.
// Path: an accepted word waits in the front-to-back queue, passes 29 divider
//   stages (one quotient bit each), and is then written into the result queue,
//   where it becomes visible.
// Reset (rst_n low, synchronous): queues empty, pipeline drained, registers
//   back to 640x640 target, stretch off, ratio 16:9.
// Receiver stall: the result queue fills, the divider pipeline holds, the
//   middle queue fills, and in_full rises; nothing is dropped.
`default_nettype none
module letterbox_resize_geometry (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [lrg_pkg::IDX_W-1:0] cfg_idx,
  input  wire logic [lrg_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire logic [lrg_pkg::DIM_W-1:0] in_src_width,
  input  wire logic [lrg_pkg::DIM_W-1:0] in_src_height,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output logic [1:0]                     out_status,
  output logic                           out_aspect_kept,
  output logic [lrg_pkg::DIM_W-1:0]      out_out_width,
  output logic [lrg_pkg::DIM_W-1:0]      out_out_height,
  output logic [lrg_pkg::DIM_W-1:0]      out_left_pad,
  output logic [lrg_pkg::DIM_W-1:0]      out_pad_top,
  output logic [lrg_pkg::DIM_W-1:0]      out_pad_right,
  output logic [lrg_pkg::DIM_W-1:0]      out_pad_bottom,
  output logic [lrg_pkg::SCL_W-1:0]      out_scale_x,
  output logic [lrg_pkg::SCL_W-1:0]      out_scale_y,
  output logic [lrg_pkg::SCL_W-1:0]      out_uniform_scale
);
  import lrg_pkg::*;

  item_t f_item, m_item;
  res_t  b_res, o_res;
  logic  mid_empty, mid_pop, res_full, res_push;

  lrg_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .src_width(in_src_width), .src_height(in_src_height),
    .item(f_item));

  lrg_fifo #(.W($bits(item_t)), .DEPTH(4)) u_midq (
    .clk(clk), .rst_n(rst_n), .push(in_push), .din(f_item), .full(in_full),
    .pop(mid_pop), .dout(m_item), .empty(mid_empty));

  lrg_back u_back (
    .clk(clk), .rst_n(rst_n), .mid_empty(mid_empty), .mid_item(m_item),
    .mid_pop(mid_pop), .res_full(res_full), .res_push(res_push), .res(b_res));

  lrg_fifo #(.W($bits(res_t)), .DEPTH(4)) u_resq (
    .clk(clk), .rst_n(rst_n), .push(res_push), .din(b_res), .full(res_full),
    .pop(out_pop), .dout(o_res), .empty(out_empty));

  assign out_status        = o_res.status;
  assign out_aspect_kept   = o_res.aspect_kept;
  assign out_out_width     = o_res.out_width;
  assign out_out_height    = o_res.out_height;
  assign out_left_pad      = o_res.left_pad;
  assign out_pad_top       = o_res.pad_top;
  assign out_pad_right     = o_res.pad_right;
  assign out_pad_bottom    = o_res.pad_bottom;
  assign out_scale_x       = o_res.scale_x;
  assign out_scale_y       = o_res.scale_y;
  assign out_uniform_scale = o_res.uniform_scale;

  a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_OK) |->
      (!out_aspect_kept && out_scale_x == '0 && out_uniform_scale == '0))
    else $error("error word carries geometry");

  a_lbox_uniform: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_aspect_kept) |->
      (out_scale_x == out_uniform_scale && out_scale_y == out_uniform_scale))
    else $error("letterbox scales differ");

  a_stretch_nopad: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == ST_OK && !out_aspect_kept) |->
      (out_left_pad == '0 && out_pad_right == '0 && out_pad_top == '0 &&
       out_pad_bottom == '0 && out_uniform_scale == '0))
    else $error("stretched word has padding");

  a_odd_right: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_aspect_kept) |->
      (out_pad_right - out_left_pad <= 13'd1 && out_pad_bottom - out_pad_top <= 13'd1))
    else $error("padding split uneven");
endmodule
`default_nettype wire

// File: tb/tb_letterbox_resize_geometry.sv
// Testbench for the letterbox resize geometry block: directed and random sizes, checked by prediction.
`default_nettype none
module tb_letterbox_resize_geometry;
  import lrg_pkg::*;

  // index that maps to no register
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct {
    logic [1:0]       status;
    logic             aspect_kept;
    logic [DIM_W-1:0] ow, oh, pl, pt, pr, pb;
    logic [SCL_W-1:0] sx, sy, su;
  } geom_t;

  class geom_board;
    geom_t pending[$];
    int    errors = 0;
    int    checked = 0;
    // configuration copy
    bit [DIM_W-1:0] tw = 13'd640, th = 13'd640;
    bit             stretch = 1'b0;
    bit [RAT_W-1:0] rw = 16'd16, rh = 16'd9;

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_TGT_W:   tw = v[DIM_W-1:0];
        REG_TGT_H:   th = v[DIM_W-1:0];
        REG_STRETCH: stretch = v[0];
        REG_RAT_W:   rw = v;
        REG_RAT_H:   rh = v;
        default: ;
      endcase
    endfunction

    function bit [SCL_W-1:0] round_div(longint unsigned n, longint unsigned d);
      longint unsigned q;
      q = ((n << FRAC_W) + d / 2) / d;
      return q[SCL_W-1:0];
    endfunction

    function void note_input(logic [DIM_W-1:0] sw, logic [DIM_W-1:0] sh);
      geom_t g;
      longint unsigned a, b, t_w, t_h, fw, fh, sc, remw, remh;
      g = '{default: 0};
      a = sw; b = sh; t_w = tw; t_h = th;
      if (a == 0 || a > 4096 || b == 0 || b > 4096 || t_w == 0 || t_w > 4096 ||
          t_h == 0 || t_h > 4096) begin
        g.status = ST_SIZE;
      end else if (stretch && (rw == 0 || rh == 0)) begin
        g.status = ST_POLICY;
      end else if (stretch && a * rh == b * rw) begin
        g.status = ST_OK;
        g.ow = DIM_W'(t_w); g.oh = DIM_W'(t_h);
        g.sx = round_div(t_w, a);
        g.sy = round_div(t_h, b);
      end else begin
        if (t_w * b <= t_h * a) begin
          fw = t_w;
          fh = (2 * b * t_w + a) / (2 * a);
          if (fh < 1) fh = 1;
          if (fh > t_h) fh = t_h;
          sc = round_div(t_w, a);
        end else begin
          fh = t_h;
          fw = (2 * a * t_h + b) / (2 * b);
          if (fw < 1) fw = 1;
          if (fw > t_w) fw = t_w;
          sc = round_div(t_h, b);
        end
        remw = t_w - fw; remh = t_h - fh;
        g.status = ST_OK; g.aspect_kept = 1'b1;
        g.ow = DIM_W'(fw); g.oh = DIM_W'(fh);
        g.pl = DIM_W'(remw / 2); g.pt = DIM_W'(remh / 2);
        g.pr = DIM_W'(remw - remw / 2); g.pb = DIM_W'(remh - remh / 2);
        g.sx = SCL_W'(sc); g.sy = SCL_W'(sc); g.su = SCL_W'(sc);
      end
      pending.push_back(g);
    endfunction

    function void check_result(geom_t got);
      geom_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("status", e.status, got.status);
      cmp("aspect_kept", e.aspect_kept, got.aspect_kept);
      cmp("out_width", e.ow, got.ow);
      cmp("out_height", e.oh, got.oh);
      cmp("left_pad", e.pl, got.pl);
      cmp("pad_top", e.pt, got.pt);
      cmp("pad_right", e.pr, got.pr);
      cmp("pad_bottom", e.pb, got.pb);
      cmp("scale_x", e.sx, got.sx);
      cmp("scale_y", e.sy, got.sy);
      cmp("uniform_scale", e.su, got.su);
    endfunction

    function void cmp(string name, longint unsigned e, longint unsigned a);
      if (e !== a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_push = 0, out_pop = 0;
  logic in_full, out_empty;
  logic [DIM_W-1:0] in_src_width = '0, in_src_height = '0;
  logic [1:0] o_status;
  logic o_kept;
  logic [DIM_W-1:0] o_w, o_h, o_pl, o_pt, o_pr, o_pb;
  logic [SCL_W-1:0] o_sx, o_sy, o_su;

  int send_idle = 0, recv_idle = 0;
  bit done_sending = 0;
  int sent = 0;
  geom_board board = new();

  letterbox_resize_geometry dut (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .in_push, .in_full,
    .in_src_width, .in_src_height, .out_empty, .out_pop,
    .out_status(o_status), .out_aspect_kept(o_kept), .out_out_width(o_w),
    .out_out_height(o_h), .out_left_pad(o_pl), .out_pad_top(o_pt),
    .out_pad_right(o_pr), .out_pad_bottom(o_pb), .out_scale_x(o_sx),
    .out_scale_y(o_sy), .out_uniform_scale(o_su));

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // receiver: pop at random, check each word taken
  always @(posedge clk) begin
    geom_t g;
    if (rst_n && out_pop && !out_empty) begin
      g.status = o_status; g.aspect_kept = o_kept;
      g.ow = o_w; g.oh = o_h; g.pl = o_pl; g.pt = o_pt; g.pr = o_pr; g.pb = o_pb;
      g.sx = o_sx; g.sy = o_sy; g.su = o_su;
      board.check_result(g);
    end
    out_pop <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  task automatic write_cfg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= v;
    @(posedge clk);
    board.write_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // hold the word until the block takes it
  task automatic send_size(logic [DIM_W-1:0] sw, logic [DIM_W-1:0] sh);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 0;
      @(posedge clk);
    end
    in_push <= 1; in_src_width <= sw; in_src_height <= sh;
    @(posedge clk);
    while (in_full) @(posedge clk);
    board.note_input(sw, sh);
    sent++;
  endtask

  task automatic drain();
    in_push <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [DIM_W-1:0] rand_dim();
    int r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 8) return DIM_W'($urandom_range(8191, 4097));
    if (r < 12) return DIM_W'(4096);
    if (r < 50) return DIM_W'($urandom_range(64, 1));
    return DIM_W'($urandom_range(4096, 1));
  endfunction

  task automatic random_phase(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      // matching sizes hit the stretch path
      if (board.stretch && board.rw != 0 && board.rh != 0 && board.rw <= 4096 &&
          board.rh <= 4096 && $urandom_range(2) == 0) begin
        k = $urandom_range(4096 / (board.rw > board.rh ? board.rw : board.rh), 1);
        send_size(DIM_W'(board.rw * k), DIM_W'(board.rh * k));
      end else begin
        send_size(rand_dim(), rand_dim());
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, errors, equal ratios, odd pads
    send_size(0, 100); send_size(100, 0); send_size(8191, 8191);
    send_size(4096, 4096); send_size(1, 1); send_size(1, 4096);
    send_size(4096, 1); send_size(640, 640); send_size(1920, 1080);
    send_size(1080, 1920); send_size(641, 3); send_size(4097, 4096);
    drain();
    write_cfg(REG_STRETCH, 1);
    send_size(1920, 1080); send_size(16, 9); send_size(1920, 1081);
    drain();
    write_cfg(REG_RAT_W, 0);
    send_size(1920, 1080);
    drain();
    write_cfg(REG_RAT_W, 16); write_cfg(REG_RAT_H, 0);
    send_size(1920, 1080);
    drain();
    write_cfg(REG_TGT_W, 0); write_cfg(REG_TGT_H, 4096); write_cfg(REG_RAT_H, 9);
    send_size(100, 100);
    drain();
    write_cfg(REG_TGT_W, 8191);
    send_size(100, 100);
    drain();
    write_cfg(REG_TGT_W, 1); write_cfg(REG_NONE, 16'hFFFF);
    send_size(4096, 1); send_size(3, 4096);
    drain();

    send_idle = 33; recv_idle = 59;
    write_cfg(REG_TGT_W, 640); write_cfg(REG_TGT_H, 640); write_cfg(REG_STRETCH, 0);
    random_phase(200);
    drain();
    send_idle = 59; recv_idle = 33;
    write_cfg(REG_TGT_W, 4096); write_cfg(REG_TGT_H, 1);
    write_cfg(REG_STRETCH, 1); write_cfg(REG_RAT_W, 4); write_cfg(REG_RAT_H, 3);
    random_phase(200);
    drain();
    send_idle = 0; recv_idle = 0;
    write_cfg(REG_TGT_W, 1); write_cfg(REG_TGT_H, 4096);
    write_cfg(REG_RAT_W, 1); write_cfg(REG_RAT_H, 1);
    random_phase(200);
    drain();
    write_cfg(REG_TGT_W, CFG_W'($urandom_range(4096, 1)));
    write_cfg(REG_TGT_H, CFG_W'($urandom_range(4096, 1)));
    write_cfg(REG_RAT_W, 16'hFFFF); write_cfg(REG_RAT_H, CFG_W'($urandom_range(65535, 1)));
    random_phase(200);
    drain();
    write_cfg(REG_RAT_W, 16); write_cfg(REG_RAT_H, 9);
    write_cfg(REG_TGT_W, 1920); write_cfg(REG_TGT_H, 1080);
    random_phase(220);
    drain();

    $display("Sent %0d source sizes over several target, stretch and ratio settings;", sent);
    $display("checked %0d results with random stalls on both sides.", board.checked);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
